FILE: rtl/utf8_to_ucs2_decoder_assert.svh
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 decoder assertion macros
// Shared property forms for the decoder's checker.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UCS2_DECODER_ASSERT_SVH
`define UTF8_TO_UCS2_DECODER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define U2U_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define U2U_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/u2u_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 decoder package
// Types, constants and the lead byte table shared by the decoder files.
// ----------------------------------------------------------------------------
`default_nettype none

package u2u_pkg;

   localparam int BYTE_W    = 8;
   localparam int CHAR_W    = 16;
   localparam int COUNT_W   = 16;
   localparam int ACC_W     = 20;
   localparam int EXTRA_W   = 3;
   localparam int STATUS_W  = 2;
   localparam int SHIFT_W   = 6;

   // Power of two, so the queue pointers wrap on their own
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [COUNT_W-1:0] CAPACITY_RESET = 16'hFFFF;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ILLEGAL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TRUNCATE = 2'd2;

   // Low 16 bits of the standard offsets for one and two extra bytes
   localparam logic [CHAR_W-1:0] OFFSET_ONE = 16'h3080;
   localparam logic [CHAR_W-1:0] OFFSET_TWO = 16'h2080;

   localparam logic [EXTRA_W-1:0] EXTRA_NONE  = 3'd0;
   localparam logic [EXTRA_W-1:0] EXTRA_ONE   = 3'd1;
   localparam logic [EXTRA_W-1:0] EXTRA_TWO   = 3'd2;
   localparam logic [EXTRA_W-1:0] EXTRA_THREE = 3'd3;
   localparam logic [EXTRA_W-1:0] EXTRA_FOUR  = 3'd4;
   localparam logic [EXTRA_W-1:0] EXTRA_FIVE  = 3'd5;

   typedef struct packed {
      logic [BYTE_W-1:0]  in_byte;
      logic               last_byte;
      logic [EXTRA_W-1:0] extra;
   } u2u_item_type;

   function automatic logic [EXTRA_W-1:0] extra_for(input logic [BYTE_W-1:0] b);
      logic [EXTRA_W-1:0] e;
      if (b < 8'hC0)      e = EXTRA_NONE;
      else if (b < 8'hE0) e = EXTRA_ONE;
      else if (b < 8'hF0) e = EXTRA_TWO;
      else if (b < 8'hF8) e = EXTRA_THREE;
      else if (b < 8'hFC) e = EXTRA_FOUR;
      else                e = EXTRA_FIVE;
      return e;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/u2u_ifs.sv
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 decoder channel interfaces
// Byte request, character response and capacity write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface u2u_req_if import u2u_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              last_byte;
   modport source (output valid, in_byte, last_byte, input ready);
   modport sink   (input valid, in_byte, last_byte, output ready);
endinterface

interface u2u_rsp_if import u2u_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CHAR_W-1:0]   char_out;
   logic                char_valid;
   logic                done_res;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  bytes_consumed;
   logic [COUNT_W-1:0]  chars_written;
   modport source (output valid, char_out, char_valid, done_res, status,
                   bytes_consumed, chars_written, input ready);
   modport sink   (input valid, char_out, char_valid, done_res, status,
                   bytes_consumed, chars_written, output ready);
endinterface

interface u2u_csr_if import u2u_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] write_data;
   modport source (output valid, write_data, input ready);
   modport sink   (input valid, write_data, output ready);
endinterface

`default_nettype wire

FILE: rtl/u2u_front.sv
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 decoder front stage
// Accepts source bytes and tags each with the extra byte count of a lead byte.
// ----------------------------------------------------------------------------
`default_nettype none

module u2u_front import u2u_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   u2u_req_if.sink           req_ch,
   output logic              item_valid,
   output u2u_item_type      item,
   input  wire logic         item_ready
);

   logic         valid_ff, valid_in;
   u2u_item_type item_ff, item_in;
   logic         take;

   assign req_ch.ready = !valid_ff || item_ready;
   assign take         = req_ch.valid && req_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (take) begin
         valid_in          = 1'b1;
         item_in.in_byte   = req_ch.in_byte;
         item_in.last_byte = req_ch.last_byte;
         item_in.extra     = extra_for(req_ch.in_byte);
      end else if (item_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

FILE: rtl/u2u_queue.sv
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 decoder item queue
// Short first-in first-out buffer between the front and back stages.
// ----------------------------------------------------------------------------
`default_nettype none

module u2u_queue import u2u_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push_valid,
   input  wire u2u_item_type  push_item,
   output logic               push_ready,
   output logic               pop_valid,
   output u2u_item_type       pop_item,
   input  wire logic          pop_ready
);

   u2u_item_type           entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   push, pop;

   assign push_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = rd_ptr_ff + 1'b1;
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) entry_ff[wr_ptr_ff] <= push_item;
   end

endmodule

`default_nettype wire

FILE: rtl/u2u_back.sv
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 decoder back stage
// Runs the sequence state, counts, stop handling and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module u2u_back import u2u_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          item_valid,
   input  wire u2u_item_type  item,
   output logic               item_ready,
   u2u_csr_if.sink            csr_ch,
   u2u_rsp_if.source          rsp_ch
);

   logic [COUNT_W-1:0]  cap_ff, cap_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [EXTRA_W-1:0]  need_ff, need_in;
   logic [EXTRA_W-1:0]  seen_ff, seen_in;
   logic                in_seq_ff, in_seq_in;
   logic                full_ff, full_in;
   logic                drain_ff, drain_in;
   logic [COUNT_W-1:0]  chars_ff, chars_in;
   logic [COUNT_W-1:0]  bytes_ff, bytes_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]   char_ff, char_in;
   logic                char_valid_ff, char_valid_in;
   logic                done_ff, done_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [COUNT_W-1:0]  consumed_ff, consumed_in;
   logic [COUNT_W-1:0]  written_ff, written_in;

   logic                pop;
   logic                lead;
   logic [ACC_W-1:0]    acc_cur;
   logic [EXTRA_W-1:0]  need_cur, seen_cur;
   logic                full_cur;
   logic [CHAR_W-1:0]   offset;
   logic                stop;
   logic [STATUS_W-1:0] stop_status;

   assign csr_ch.ready = 1'b1;
   assign item_ready   = !rsp_valid_ff || rsp_ch.ready;
   assign pop          = item_valid && item_ready;

   assign lead     = !in_seq_ff;
   assign need_cur = lead ? item.extra : need_ff;
   assign seen_cur = lead ? EXTRA_NONE : seen_ff + 1'b1;
   assign acc_cur  = lead ? ACC_W'(item.in_byte)
                          : ACC_W'({acc_ff, {SHIFT_W{1'b0}}}) + ACC_W'(item.in_byte);
   assign full_cur = lead ? (chars_ff >= cap_ff) : full_ff;

   always_comb begin
      case (need_cur)
         EXTRA_ONE: offset = OFFSET_ONE;
         EXTRA_TWO: offset = OFFSET_TWO;
         default:   offset = '0;
      endcase
   end

   always_comb begin
      cap_in   = cap_ff;
      acc_in   = acc_ff;
      need_in  = need_ff;
      seen_in  = seen_ff;
      in_seq_in = in_seq_ff;
      full_in  = full_ff;
      drain_in = drain_ff;
      chars_in = chars_ff;
      bytes_in = bytes_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      char_in       = char_ff;
      char_valid_in = char_valid_ff;
      done_in       = done_ff;
      status_in     = status_ff;
      consumed_in   = consumed_ff;
      written_in    = written_ff;

      stop        = 1'b0;
      stop_status = STATUS_OK;

      if (csr_ch.valid) cap_in = csr_ch.write_data;

      if (pop) begin
         if (drain_ff) begin
            // drop the rest of the buffer
            if (item.last_byte) begin
               drain_in = 1'b0;
               in_seq_in = 1'b0;
               chars_in = '0;
               bytes_in = '0;
            end
         end else begin
            acc_in  = acc_cur;
            need_in = need_cur;
            seen_in = seen_cur;
            full_in = full_cur;
            if (seen_cur < need_cur) begin
               in_seq_in = 1'b1;
               if (item.last_byte) begin
                  stop        = 1'b1;
                  stop_status = STATUS_ILLEGAL;
               end
            end else begin
               in_seq_in = 1'b0;
               if (full_cur) begin
                  stop        = 1'b1;
                  stop_status = STATUS_TRUNCATE;
               end else if (need_cur >= EXTRA_THREE) begin
                  stop        = 1'b1;
                  stop_status = STATUS_ILLEGAL;
               end
            end

            if (stop) begin
               rsp_valid_in  = 1'b1;
               char_in       = '0;
               char_valid_in = 1'b0;
               done_in       = 1'b1;
               status_in     = stop_status;
               consumed_in   = bytes_ff;
               written_in    = chars_ff;
               in_seq_in     = 1'b0;
               if (item.last_byte) begin
                  chars_in = '0;
                  bytes_in = '0;
               end else begin
                  drain_in = 1'b1;
               end
            end else if (!in_seq_in) begin
               chars_in      = chars_ff + 1'b1;
               bytes_in      = bytes_ff + COUNT_W'(need_cur) + 1'b1;
               rsp_valid_in  = 1'b1;
               char_in       = acc_cur[CHAR_W-1:0] - offset;
               char_valid_in = 1'b1;
               done_in       = item.last_byte;
               status_in     = STATUS_OK;
               consumed_in   = item.last_byte ? bytes_in : '0;
               written_in    = item.last_byte ? chars_in : '0;
               if (item.last_byte) begin
                  chars_in = '0;
                  bytes_in = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAPACITY_RESET;
         acc_ff       <= '0;
         need_ff      <= '0;
         seen_ff      <= '0;
         in_seq_ff    <= 1'b0;
         full_ff      <= 1'b0;
         drain_ff     <= 1'b0;
         chars_ff     <= '0;
         bytes_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         acc_ff       <= acc_in;
         need_ff      <= need_in;
         seen_ff      <= seen_in;
         in_seq_ff    <= in_seq_in;
         full_ff      <= full_in;
         drain_ff     <= drain_in;
         chars_ff     <= chars_in;
         bytes_ff     <= bytes_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      char_ff       <= char_in;
      char_valid_ff <= char_valid_in;
      done_ff       <= done_in;
      status_ff     <= status_in;
      consumed_ff   <= consumed_in;
      written_ff    <= written_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.char_out       = char_ff;
   assign rsp_ch.char_valid     = char_valid_ff;
   assign rsp_ch.done_res       = done_ff;
   assign rsp_ch.status         = status_ff;
   assign rsp_ch.bytes_consumed = consumed_ff;
   assign rsp_ch.chars_written  = written_ff;

endmodule

`default_nettype wire

FILE: rtl/utf8_to_ucs2_decoder.sv
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 decoder
// Top level: front classifier, item queue and back sequencer.
// ----------------------------------------------------------------------------
// Decodes one source byte per clock while rsp_ch is not stalled. A byte
// accepted on req_ch is classified in the front register, passes through a
// two-entry queue and is folded into the sequence state by the back
// sequencer, whose output register drives rsp_ch with its result, if any.
// The back sequencer handles one byte per cycle, so that loop sets the rate;
// a stalled rsp_ch fills the queue and front register before req_ch drops
// ready. The capacity register on csr_ch is always ready and is meant to be
// written between buffers.
`default_nettype none

module utf8_to_ucs2_decoder import u2u_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   u2u_req_if.sink   req_ch,
   u2u_rsp_if.source rsp_ch,
   u2u_csr_if.sink   csr_ch
);

   logic         front_valid, front_ready;
   u2u_item_type front_item;
   logic         queue_valid, queue_ready;
   u2u_item_type queue_item;

   u2u_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .item_valid (front_valid),
      .item       (front_item),
      .item_ready (front_ready)
   );

   u2u_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_item  (front_item),
      .push_ready (front_ready),
      .pop_valid  (queue_valid),
      .pop_item   (queue_item),
      .pop_ready  (queue_ready)
   );

   u2u_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (queue_valid),
      .item       (queue_item),
      .item_ready (queue_ready),
      .csr_ch     (csr_ch),
      .rsp_ch     (rsp_ch)
   );

endmodule

`default_nettype wire

FILE: rtl/u2u_checker.sv
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 decoder checker
// Port-level properties of the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf8_to_ucs2_decoder_assert.svh"

module u2u_checker import u2u_pkg::*; (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [CHAR_W-1:0]   char_out,
   input wire logic                char_valid,
   input wire logic                done_res,
   input wire logic [STATUS_W-1:0] status,
   input wire logic [COUNT_W-1:0]  bytes_consumed,
   input wire logic [COUNT_W-1:0]  chars_written
);

   // Hold a stalled transaction
   `U2U_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(char_out) && $stable(status) && $stable(done_res),
      "stalled response changed")

   // Any result without a character closes the buffer
   `U2U_ASSERT_IMPLY(a_nochar_done, clock, reset, rsp_valid && !char_valid,
      done_res && status != STATUS_OK, "result without character is not a stop")

   // A stop status only travels with done and never with a character
   `U2U_ASSERT_IMPLY(a_status_done, clock, reset, rsp_valid && status != STATUS_OK,
      done_res && !char_valid && char_out == '0, "stop status on a non-final result")

   // Counts are zero except on the closing result
   `U2U_ASSERT_IMPLY(a_counts_zero, clock, reset, rsp_valid && !done_res,
      bytes_consumed == '0 && chars_written == '0, "counts on a non-final result")

endmodule

bind utf8_to_ucs2_decoder u2u_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .char_out       (rsp_ch.char_out),
   .char_valid     (rsp_ch.char_valid),
   .done_res       (rsp_ch.done_res),
   .status         (rsp_ch.status),
   .bytes_consumed (rsp_ch.bytes_consumed),
   .chars_written  (rsp_ch.chars_written)
);

`default_nettype wire

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 decoder testbench
// Drives byte buffers into the decoder under random idling and back pressure,
// predicts each character and end-of-buffer result in a scoreboard, and
// compares every result transaction field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
   import u2u_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int HOLD_CYCLES = 250;
   localparam int PHASE_BYTES = 185;

   // {last_byte, in_byte}
   localparam logic [8:0] DIRECTED_BYTES [22] = '{
      9'h100,
      9'h07F, 9'h0C2, 9'h080, 9'h0DF, 9'h0BF, 9'h0EF, 9'h0BF, 9'h0BF, 9'h0E0,
      9'h080, 9'h180,
      9'h1C3,
      9'h0F0, 9'h080, 9'h080, 9'h080, 9'h041, 9'h142,
      9'h1FF,
      9'h080, 9'h1BF
   };

   typedef struct packed {
      logic [CHAR_W-1:0]   char_out;
      logic                char_valid;
      logic                done_res;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  bytes_consumed;
      logic [COUNT_W-1:0]  chars_written;
   } ucs2_result_type;

   function automatic logic [EXTRA_W-1:0] utf8_extra_count(input logic [BYTE_W-1:0] b);
      casez (b)
         8'b0???????, 8'b10??????: return EXTRA_NONE;
         8'b110?????:              return EXTRA_ONE;
         8'b1110????:              return EXTRA_TWO;
         8'b11110???:              return EXTRA_THREE;
         8'b111110??:              return EXTRA_FOUR;
         default:                  return EXTRA_FIVE;
      endcase
   endfunction

   class ucs2_scoreboard;
      logic [COUNT_W-1:0] capacity;
      logic [ACC_W-1:0]   acc;
      logic [EXTRA_W-1:0] need;
      logic [EXTRA_W-1:0] seen;
      logic               in_seq;
      logic               full_at_lead;
      logic               draining;
      logic [COUNT_W-1:0] char_count;
      logic [COUNT_W-1:0] byte_count;
      ucs2_result_type    expected_chars[$];
      int                 mismatch_count;

      function void power_on();
         capacity = CAPACITY_RESET;
         mismatch_count = 0;
         restart_buffer();
      endfunction

      function void restart_buffer();
         acc = '0;
         need = EXTRA_NONE;
         seen = EXTRA_NONE;
         in_seq = 1'b0;
         full_at_lead = 1'b0;
         draining = 1'b0;
         char_count = '0;
         byte_count = '0;
      endfunction

      function void stop_buffer(input logic [STATUS_W-1:0] status, input logic last);
         ucs2_result_type r;
         r = '0;
         r.done_res = 1'b1;
         r.status = status;
         r.bytes_consumed = byte_count;
         r.chars_written = char_count;
         expected_chars.push_back(r);
         if (last) begin
            restart_buffer();
         end else begin
            in_seq = 1'b0;
            draining = 1'b1;
         end
      endfunction

      function void note_byte(input logic [BYTE_W-1:0] b, input logic last);
         ucs2_result_type   r;
         logic [CHAR_W-1:0] offset;
         if (draining) begin
            if (last) restart_buffer();
            return;
         end
         if (!in_seq) begin
            need = utf8_extra_count(b);
            seen = EXTRA_NONE;
            acc = ACC_W'(b);
            full_at_lead = (char_count >= capacity);
            in_seq = 1'b1;
         end else begin
            acc = (acc << SHIFT_W) + ACC_W'(b);
            seen = seen + 1'b1;
         end
         if (seen < need) begin
            // overrun beats a full destination
            if (last) stop_buffer(STATUS_ILLEGAL, 1'b1);
            return;
         end
         in_seq = 1'b0;
         if (full_at_lead) begin
            stop_buffer(STATUS_TRUNCATE, last);
            return;
         end
         if (need >= EXTRA_THREE) begin
            stop_buffer(STATUS_ILLEGAL, last);
            return;
         end
         case (need)
            EXTRA_ONE: offset = OFFSET_ONE;
            EXTRA_TWO: offset = OFFSET_TWO;
            default:   offset = '0;
         endcase
         r = '0;
         r.char_out = acc[CHAR_W-1:0] - offset;
         r.char_valid = 1'b1;
         char_count = char_count + 1'b1;
         byte_count = byte_count + COUNT_W'(need) + 1'b1;
         if (last) begin
            r.done_res = 1'b1;
            r.status = STATUS_OK;
            r.bytes_consumed = byte_count;
            r.chars_written = char_count;
            restart_buffer();
         end
         expected_chars.push_back(r);
      endfunction

      function void compare_field(input string name, input logic [COUNT_W-1:0] want,
                                  input logic [COUNT_W-1:0] got);
         if (want != got) begin
            $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
         end
      endfunction

      function void check_char(input ucs2_result_type got);
         ucs2_result_type want;
         if (expected_chars.size() == 0) begin
            $display("%0t: result with none outstanding, expected nothing, actual %h",
                     $time, got);
            mismatch_count++;
            return;
         end
         want = expected_chars.pop_front();
         compare_field("char_out", COUNT_W'(want.char_out), COUNT_W'(got.char_out));
         compare_field("char_valid", COUNT_W'(want.char_valid), COUNT_W'(got.char_valid));
         compare_field("done_res", COUNT_W'(want.done_res), COUNT_W'(got.done_res));
         compare_field("status", COUNT_W'(want.status), COUNT_W'(got.status));
         compare_field("bytes_consumed", want.bytes_consumed, got.bytes_consumed);
         compare_field("chars_written", want.chars_written, got.chars_written);
      endfunction

      function int outstanding();
         return expected_chars.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   u2u_req_if req_ch ();
   u2u_rsp_if rsp_ch ();
   u2u_csr_if csr_ch ();

   utf8_to_ucs2_decoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   ucs2_scoreboard decoder_sb;
   int             tx_idle_pct;
   int             rx_idle_pct;
   int             hold_token;
   int             sent_count;
   int             cycle_count;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // result side: check, then choose ready for the next edge
   initial begin
      int              hold_seen;
      int              hold_left;
      ucs2_result_type got;
      hold_seen = 0;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.char_out, rsp_ch.char_valid, rsp_ch.done_res, rsp_ch.status,
                   rsp_ch.bytes_consumed, rsp_ch.chars_written};
            decoder_sb.check_char(got);
         end
         if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.in_byte <= b;
      req_ch.last_byte <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      decoder_sb.note_byte(b, last);
      sent_count++;
   endtask

   // drop valid, wait for every expected transaction, then cover bytes still in flight
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (decoder_sb.outstanding() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [COUNT_W-1:0] value);
      wait_drained();
      csr_ch.valid <= 1'b1;
      csr_ch.write_data <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      decoder_sb.capacity = value;
   endtask

   task automatic send_buffer();
      logic [BYTE_W-1:0]  bytes_q[$];
      logic [BYTE_W-1:0]  lead;
      logic [EXTRA_W-1:0] extra;
      int                 nseq;
      int                 pick;
      int                 cut;
      nseq = $urandom_range(1, 8);
      for (int s = 0; s < nseq; s++) begin
         pick = $urandom_range(99);
         if (pick < 35) begin
            bytes_q.push_back(BYTE_W'($urandom_range(8'h00, 8'h7F)));
         end else if (pick < 60) begin
            bytes_q.push_back(BYTE_W'($urandom_range(8'hC0, 8'hDF)));
            bytes_q.push_back(BYTE_W'($urandom_range(8'h80, 8'hBF)));
         end else if (pick < 80) begin
            bytes_q.push_back(BYTE_W'($urandom_range(8'hE0, 8'hEF)));
            bytes_q.push_back(BYTE_W'($urandom_range(8'h80, 8'hBF)));
            bytes_q.push_back(BYTE_W'($urandom_range(8'h80, 8'hBF)));
         end else if (pick < 88) begin
            lead = BYTE_W'($urandom_range(8'hF0, 8'hFF));
            bytes_q.push_back(lead);
            for (int k = 0; k < utf8_extra_count(lead); k++)
               bytes_q.push_back(BYTE_W'($urandom_range(8'h80, 8'hBF)));
         end else begin
            bytes_q.push_back(BYTE_W'($urandom_range(8'h00, 8'hFF)));
         end
      end
      // cut the buffer inside a sequence now and then
      if ($urandom_range(99) < 15) begin
         lead = BYTE_W'($urandom_range(8'hC0, 8'hFF));
         extra = utf8_extra_count(lead);
         bytes_q.push_back(lead);
         cut = $urandom_range(0, extra - 1);
         for (int k = 0; k < cut; k++)
            bytes_q.push_back(BYTE_W'($urandom_range(8'h00, 8'hFF)));
      end
      foreach (bytes_q[i])
         send_byte(bytes_q[i], i == bytes_q.size() - 1);
   endtask

   initial begin
      logic [COUNT_W-1:0] cap;
      int                 phase_end;
      int                 nbuf;
      decoder_sb = new();
      decoder_sb.power_on();
      tx_idle_pct = 10;
      rx_idle_pct = 66;
      hold_token = 0;
      sent_count = 0;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.in_byte <= '0;
      req_ch.last_byte <= 1'b0;
      csr_ch.valid <= 1'b0;
      csr_ch.write_data <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED_BYTES[i])
         send_byte(DIRECTED_BYTES[i][7:0], DIRECTED_BYTES[i][8]);
      write_capacity('0);
      send_byte(8'h41, 1'b1);
      send_byte(8'hE5, 1'b1);

      for (int phase = 0; phase < 9; phase++) begin
         case (phase)
            0:       cap = 16'd1;
            1:       cap = '0;
            2:       cap = 16'd3;
            3:       cap = CAPACITY_RESET;
            4:       cap = 16'd2;
            5:       cap = COUNT_W'($urandom_range(0, 65535));
            6:       cap = COUNT_W'($urandom_range(4, 10));
            7:       cap = 16'd5;
            default: cap = CAPACITY_RESET;
         endcase
         write_capacity(cap);
         if (phase < 3) begin
            tx_idle_pct = 10;
            rx_idle_pct = 66;
         end else if (phase < 6) begin
            tx_idle_pct = 66;
            rx_idle_pct = 10;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         phase_end = sent_count + PHASE_BYTES;
         nbuf = 0;
         while (sent_count < phase_end) begin
            if (phase == 1 && nbuf == 1) hold_token++;
            if (phase == 4 && nbuf == 3) wait_drained();
            send_buffer();
            nbuf++;
         end
      end

      wait_drained();
      if (decoder_sb.mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/u2u_pkg.sv
rtl/u2u_ifs.sv
rtl/u2u_front.sv
rtl/u2u_queue.sv
rtl/u2u_back.sv
rtl/utf8_to_ucs2_decoder.sv
rtl/u2u_checker.sv
tb/sv/testbench.sv
